// ===== hdl/slbf_pkg.sv =====
// Shared types, constants and codes for the stop line box filter detector.
package slbf_pkg;

  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 144;
  localparam int EDGE_MARGIN_DEF  = 20;

  // Fixed by the register and field widths.
  localparam int ROW_W   = 8;   // integral row index
  localparam int SROW_W  = 10;  // signed row with box offsets
  localparam int SCOL_W  = 12;  // signed column with window and box offsets
  localparam int CNT_W   = 10;  // scoring column count
  localparam int CFG_W   = 20;
  localparam int CIDX_W  = 3;
  localparam int KSEL_W  = 3;   // eight corner reads per column

  localparam logic [9:0]  ROW_THR_RST  = 10'd85;
  localparam logic [19:0] RESP_THR_RST = 20'd20000;
  localparam logic [3:0]  BOX_HW_RST   = 4'd5;
  localparam logic [2:0]  BOX_HH_RST   = 3'd5;
  localparam logic [8:0]  WIN_HW_RST   = 9'd80;
  localparam logic [9:0]  WIN_CTR_RST  = 10'd320;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ROW_THR  = 3'd0,
    CFG_RESP_THR = 3'd1,
    CFG_BOX_HW   = 3'd2,
    CFG_BOX_HH   = 3'd3,
    CFG_WIN_HW   = 3'd4,
    CFG_WIN_CTR  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic pixel_set;
    logic frame_end;
  } in_t;

  typedef struct packed {
    logic             stop_found;
    logic [7:0]       stop_row;
    logic [CNT_W-1:0] row_score_count;
  } out_t;

  typedef struct packed {
    logic [9:0]  row_threshold;
    logic [19:0] response_threshold;
    logic [3:0]  box_half_width;
    logic [2:0]  box_half_height;
    logic [8:0]  window_half_width;
    logic [9:0]  window_center;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_SC_ROW,
    ST_SC_ADDR,
    ST_SC_READ,
    ST_SC_ACC,
    ST_SC_EVAL,
    ST_SC_ROWEND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic cap;        // take a pixel beat
    logic rd;         // read store at address register
    logic ld_wr;      // write integral entry
    logic scan_start; // first scan row
    logic row_init;   // first column, clear count
    logic addr;       // form corner address
    logic acc;        // accumulate corner
    logic col_step;   // score column, next column
    logic row_step;   // next row
    logic emit;       // load result register
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic rd_last;
    logic col_last;
    logic row_last;
    logic row_hit;
    logic out_busy;
  } sts_t;

endpackage

// ===== hdl/slbf_ctrl.sv =====
// Controller state machine for loading and scanning.
module slbf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output slbf_pkg::cmd_t cmd,
  input  slbf_pkg::sts_t sts
);

  slbf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slbf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slbf_pkg::ST_IDLE:      if (in_valid) state_nxt = slbf_pkg::ST_LD_RD;
      slbf_pkg::ST_LD_RD:     state_nxt = slbf_pkg::ST_LD_WR;
      slbf_pkg::ST_LD_WR:     state_nxt = sts.frame_end ? slbf_pkg::ST_SC_ROW
                                                        : slbf_pkg::ST_IDLE;
      slbf_pkg::ST_SC_ROW:    state_nxt = slbf_pkg::ST_SC_ADDR;
      slbf_pkg::ST_SC_ADDR:   state_nxt = slbf_pkg::ST_SC_READ;
      slbf_pkg::ST_SC_READ:   state_nxt = slbf_pkg::ST_SC_ACC;
      slbf_pkg::ST_SC_ACC:    state_nxt = sts.rd_last ? slbf_pkg::ST_SC_EVAL
                                                      : slbf_pkg::ST_SC_ADDR;
      slbf_pkg::ST_SC_EVAL:   state_nxt = sts.col_last ? slbf_pkg::ST_SC_ROWEND
                                                       : slbf_pkg::ST_SC_ADDR;
      slbf_pkg::ST_SC_ROWEND: state_nxt = (sts.row_hit || sts.row_last) ?
                                          slbf_pkg::ST_DONE : slbf_pkg::ST_SC_ROW;
      slbf_pkg::ST_DONE:      if (!sts.out_busy) state_nxt = slbf_pkg::ST_IDLE;
      default:                state_nxt = slbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      slbf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      slbf_pkg::ST_LD_RD:  cmd.rd = 1'b1;
      slbf_pkg::ST_LD_WR: begin
        cmd.ld_wr      = 1'b1;
        cmd.scan_start = sts.frame_end;
      end
      slbf_pkg::ST_SC_ROW:    cmd.row_init = 1'b1;
      slbf_pkg::ST_SC_ADDR:   cmd.addr     = 1'b1;
      slbf_pkg::ST_SC_READ:   cmd.rd       = 1'b1;
      slbf_pkg::ST_SC_ACC:    cmd.acc      = 1'b1;
      slbf_pkg::ST_SC_EVAL:   cmd.col_step = 1'b1;
      slbf_pkg::ST_SC_ROWEND: cmd.row_step = !sts.row_hit && !sts.row_last;
      slbf_pkg::ST_DONE:      cmd.emit     = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== hdl/slbf_datapath.sv =====
// Integral image store, box filter accumulator and result register.
module slbf_datapath #(
  parameter int FRAME_WIDTH  = slbf_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = slbf_pkg::FRAME_HEIGHT_DEF,
  parameter int EDGE_MARGIN  = slbf_pkg::EDGE_MARGIN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  slbf_pkg::cmd_t cmd,
  output slbf_pkg::sts_t sts,
  input  slbf_pkg::cfg_t cfg,
  input  slbf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output slbf_pkg::out_t out_data
);

  localparam int STORE_COLS  = FRAME_WIDTH + 1;
  localparam int STORE_DEPTH = STORE_COLS * (FRAME_HEIGHT + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(FRAME_WIDTH + 1);
  localparam int VAL_W       = $clog2(FRAME_WIDTH * FRAME_HEIGHT + 1);
  localparam int ACC_W       = VAL_W + 4;
  localparam int RESP_W      = ACC_W + 9;
  localparam int ROW_W       = slbf_pkg::ROW_W;
  localparam int SROW_W      = slbf_pkg::SROW_W;
  localparam int SCOL_W      = slbf_pkg::SCOL_W;
  localparam int CNT_W       = slbf_pkg::CNT_W;
  localparam logic [ROW_W-1:0] Y_FIRST = ROW_W'(EDGE_MARGIN);
  localparam logic [ROW_W-1:0] Y_LAST  = ROW_W'(FRAME_HEIGHT - EDGE_MARGIN);

  logic [VAL_W-1:0]  mem [STORE_DEPTH];
  logic [VAL_W-1:0]  rdata_r;
  logic [ADDR_W-1:0] addr_r, wr_addr_r;

  // load side
  logic [ROW_W-1:0] load_row_r;
  logic [COL_W-1:0] load_col_r, running_r, sum_r;
  logic [COL_W-1:0] sum_nxt;
  logic             top_row_r, fend_r;

  // scan side
  logic [ROW_W-1:0]            y_r;
  logic signed [SCOL_W-1:0]    x_r, x0, x1;
  logic [slbf_pkg::KSEL_W-1:0] k_r;
  logic [CNT_W-1:0]            count_r;
  logic                        inb_r;
  logic signed [ACC_W-1:0]     acc_r, term, val;
  logic signed [RESP_W-1:0]    resp, thr2;
  logic signed [SROW_W-1:0]    ys, hh, r_off, r_sel;
  logic signed [SCOL_W-1:0]    c_sel;
  logic [1:0]                  jsel;
  logic                        neg;
  logic                        out_valid_r;
  slbf_pkg::out_t              out_r;

  assign sum_nxt = running_r + COL_W'(in_data.pixel_set);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
      running_r  <= '0;
    end else if (cmd.cap) begin
      if (in_data.frame_end) begin
        load_row_r <= '0;
        load_col_r <= '0;
        running_r  <= '0;
      end else if (load_col_r == COL_W'(FRAME_WIDTH - 1)) begin
        load_col_r <= '0;
        running_r  <= '0;
        load_row_r <= (load_row_r == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : load_row_r + 1'b1;
      end else begin
        load_col_r <= load_col_r + 1'b1;
        running_r  <= sum_nxt;
      end
    end
  end

  // corner selection: k[2:1] picks one of four row edges, k[0] right or left
  assign jsel = k_r[2:1];
  assign ys   = SROW_W'($signed({2'b00, y_r}));
  assign hh   = SROW_W'($signed({1'b0, cfg.box_half_height}));

  always_comb begin
    unique case (jsel)
      2'd0:    r_off = SROW_W'(-(3 * hh + 2));
      2'd1:    r_off = SROW_W'(-(hh + 1));
      2'd2:    r_off = hh;
      default: r_off = SROW_W'(3 * hh + 1);
    endcase
    r_sel = ys + r_off;
    if (k_r[0]) begin
      c_sel = SCOL_W'(x_r - SCOL_W'($signed({1'b0, cfg.box_half_width})) - 1);
    end else begin
      c_sel = x_r + SCOL_W'($signed({1'b0, cfg.box_half_width}));
    end
  end

  assign x0 = SCOL_W'($signed({1'b0, cfg.window_center}))
            - SCOL_W'($signed({1'b0, cfg.window_half_width}));
  assign x1 = SCOL_W'($signed({1'b0, cfg.window_center}))
            + SCOL_W'($signed({1'b0, cfg.window_half_width}));

  // coefficients of the combined response: A0 - 3*A1 + A2 + A3
  assign val  = inb_r ? ACC_W'($signed({1'b0, rdata_r})) : '0;
  assign neg  = (jsel == 2'd1) ^ k_r[0];
  always_comb begin
    term = (jsel == 2'd1) ? (val <<< 1) + val : val;
    if (neg) begin
      term = -term;
    end
  end

  assign resp = (RESP_W'(acc_r) <<< 8) - RESP_W'(acc_r);
  assign thr2 = RESP_W'($signed({1'b0, cfg.response_threshold, 1'b0}));

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      addr_r    <= ADDR_W'(load_row_r * STORE_COLS + load_col_r + 1);
      wr_addr_r <= ADDR_W'((load_row_r + 1) * STORE_COLS + load_col_r + 1);
      top_row_r <= (load_row_r == '0);
      sum_r     <= sum_nxt;
      fend_r    <= in_data.frame_end;
    end else if (cmd.addr) begin
      inb_r  <= (r_sel > 0) && (r_sel <= SROW_W'(FRAME_HEIGHT)) &&
                (c_sel > 0) && (c_sel <= SCOL_W'(FRAME_WIDTH));
      addr_r <= ADDR_W'(r_sel[ROW_W-1:0] * STORE_COLS + c_sel[COL_W-1:0]);
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr_r];
    end
    if (cmd.ld_wr) begin
      mem[wr_addr_r] <= (top_row_r ? '0 : rdata_r) + VAL_W'(sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.acc) begin
      k_r <= k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      y_r <= Y_FIRST;
    end else if (cmd.row_step) begin
      y_r <= y_r + 1'b1;
    end
    if (cmd.row_init) begin
      x_r     <= x0;
      count_r <= '0;
    end else if (cmd.col_step) begin
      x_r <= SCOL_W'(x_r + 1);
      if (resp > thr2) begin
        count_r <= count_r + 1'b1;
      end
    end
    if (cmd.acc) begin
      acc_r <= ((k_r == '0) ? '0 : acc_r) + term;
    end
  end

  // result register; a waiting beat does not hold up loading
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.stop_found      <= sts.row_hit;
      out_r.stop_row        <= sts.row_hit ? y_r : '0;
      out_r.row_score_count <= sts.row_hit ? count_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.frame_end = fend_r;
  assign sts.rd_last   = (k_r == '1);
  assign sts.col_last  = (x_r == x1);
  assign sts.row_last  = (y_r == Y_LAST);
  assign sts.row_hit   = (count_r > cfg.row_threshold);
  assign sts.out_busy  = out_valid_r && !out_ready;

endmodule

// ===== hdl/stop_line_box_filter_detector.sv =====
// Top level of the stop line box filter detector: registers, controller, datapath.
//
// Usage: binary pixels of a top-view frame enter on the in_ channel in raster
// order, one beat each, with frame_end set on the last pixel. Each pixel updates
// an integral image of set-pixel counts held in one on-chip memory of
// (FRAME_HEIGHT+1)*(FRAME_WIDTH+1) entries with one read and one write port.
// Each pixel passes through three steps: accept, read of the entry one row up, write.
// The frame_end beat then starts a scan that reads eight integral corners per
// window column, each in address, read and accumulate steps through the
// single read port; it scores window columns on rows from EDGE_MARGIN
// to FRAME_HEIGHT-EDGE_MARGIN, stopping at the first row whose scoring column
// count exceeds row_threshold. One result beat on out_ then reports
// found, row and count (all zero when no row qualifies).
// The result sits in an output register; once it is loaded the block takes
// pixels again even while the receiver stalls. A second result waits until
// the first is taken.
// Reset (rst_n low, synchronous) clears the load position, the controller and
// the output valid flag, and sets the configuration registers to defaults. The
// memory is not cleared: the scan uses only entries written by the frame.
// Write configuration through cfg_ only while the block is idle.
module stop_line_box_filter_detector #(
  parameter int FRAME_WIDTH  = slbf_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = slbf_pkg::FRAME_HEIGHT_DEF,
  parameter int EDGE_MARGIN  = slbf_pkg::EDGE_MARGIN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  slbf_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output slbf_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [slbf_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [slbf_pkg::CFG_W-1:0]    cfg_data
);

  slbf_pkg::cfg_t cfg_r;
  slbf_pkg::cmd_t cmd;
  slbf_pkg::sts_t sts;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_threshold      <= slbf_pkg::ROW_THR_RST;
      cfg_r.response_threshold <= slbf_pkg::RESP_THR_RST;
      cfg_r.box_half_width     <= slbf_pkg::BOX_HW_RST;
      cfg_r.box_half_height    <= slbf_pkg::BOX_HH_RST;
      cfg_r.window_half_width  <= slbf_pkg::WIN_HW_RST;
      cfg_r.window_center      <= slbf_pkg::WIN_CTR_RST;
    end else if (cfg_we) begin
      unique case (slbf_pkg::cfg_idx_t'(cfg_index))
        slbf_pkg::CFG_ROW_THR:  cfg_r.row_threshold      <= cfg_data[9:0];
        slbf_pkg::CFG_RESP_THR: cfg_r.response_threshold <= cfg_data[19:0];
        slbf_pkg::CFG_BOX_HW:   cfg_r.box_half_width     <= cfg_data[3:0];
        slbf_pkg::CFG_BOX_HH:   cfg_r.box_half_height    <= cfg_data[2:0];
        slbf_pkg::CFG_WIN_HW:   cfg_r.window_half_width  <= cfg_data[8:0];
        slbf_pkg::CFG_WIN_CTR:  cfg_r.window_center      <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Sequence loading and scanning.
  slbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Hold the integral image and evaluate the box filters.
  slbf_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .EDGE_MARGIN  (EDGE_MARGIN)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/slbf_checker.sv =====
// Port checker for the stop line box filter detector, bound to the top level.
module slbf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input slbf_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input slbf_pkg::out_t out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // No result right after reset.
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A frame end beat starts a scan; no pixel is taken next cycle.
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.frame_end |=> !in_ready)
    else $error("pixel taken right after frame end");

  // A miss reports zero row and count.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.stop_found |->
      out_data.stop_row == '0 && out_data.row_score_count == '0)
    else $error("miss result carries row or count");

endmodule

bind stop_line_box_filter_detector slbf_checker u_slbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
